// ===== sv/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants shared by the buffer cache list manager.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int ENTRY_COUNT = 16;
    localparam int TAG_BITS    = 32;
    localparam int REF_BITS    = 8;
    localparam int SLOTS       = ENTRY_COUNT + 2;
    localparam int LINK_W      = $clog2(SLOTS);
    localparam int IDX_W       = $clog2(ENTRY_COUNT);
    localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);

    localparam logic [LINK_W-1:0] ACT_HEAD = LINK_W'(ENTRY_COUNT);
    localparam logic [LINK_W-1:0] INA_HEAD = LINK_W'(ENTRY_COUNT + 1);
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    typedef enum logic [1:0] {
        MODE_GET  = 2'd0,
        MODE_PUT  = 2'd1,
        MODE_FREE = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_HIT       = 3'd0,
        ST_REVIVE    = 3'd1,
        ST_MISS      = 3'd2,
        ST_FULL      = 3'd3,
        ST_PUT_OK    = 3'd4,
        ST_UNDERFLOW = 3'd5
    } t_status;

    typedef struct packed {
        t_mode               mode;
        logic [TAG_BITS-1:0] block_tag;
        logic [3:0]          entry_index;
        logic [4:0]          free_limit;
    } t_in_beat;

    typedef struct packed {
        t_status    status;
        logic [3:0] result_index;
        logic       need_page;
        logic       need_read;
        logic       page_freed;
        logic [4:0] freed_count;
        logic       last;
    } t_out_beat;

    typedef enum logic [1:0] {
        U_MATCH = 2'd0,
        U_INC   = 2'd1,
        U_DEC   = 2'd2,
        U_PASS  = 2'd3
    } t_unit_op;

    typedef struct packed {
        t_unit_op            op;
        logic [TAG_BITS-1:0] tag_a;
        logic [TAG_BITS-1:0] tag_b;
        logic [REF_BITS-1:0] ref_in;
    } t_unit_req;

    typedef struct packed {
        logic                match;
        logic [REF_BITS-1:0] ref_out;
    } t_unit_rsp;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SRCH_A = 8'b0000_0010,
        S_SRCH_I = 8'b0000_0100,
        S_PUT    = 8'b0000_1000,
        S_FREE   = 8'b0001_0000,
        S_UNLINK = 8'b0010_0000,
        S_LINK   = 8'b0100_0000,
        S_EMIT   = 8'b1000_0000
    } t_state;

endpackage

// ===== sv/block_buffer_cache_lists_core.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_lists_core
// Buffer cache with active and inactive circular lists and reference counts.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one t_in_beat (get, put, free).
// Output channel: o_out_valid / i_out_stall carry t_out_beat results; the
// last beat of an item has last set. Get and put give one beat, free gives
// one beat per released page plus a closing count.
// One item at a time: o_in_stall is high from acceptance until the item's
// final beat is loaded into the output register. A sequencer walks the lists
// one entry per cycle through the shared compare unit, though a free pauses
// at each released page until that page's beat is loaded. Mode 3 gives no
// beat and is absorbed without raising o_in_stall.
// Reset clears counts, tags, valid and page flags and builds the inactive
// list from the top index down to 0; the active list starts empty.
// A stalled output holds its beat; the sequencer waits until it is taken.
// ----------------------------------------------------------------------------
module block_buffer_cache_lists_core import bbc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_state                r_state, n_state;
    t_in_beat              r_item, n_item;
    logic [LINK_W-1:0]     r_ptr, n_ptr;
    logic [CNT_W-1:0]      r_steps, n_steps;
    logic [CNT_W-1:0]      r_freed, n_freed;
    logic [IDX_W-1:0]      r_mv_e, n_mv_e;
    logic [LINK_W-1:0]     r_mv_head, n_mv_head;
    logic                  r_ret_free, n_ret_free;
    t_out_beat             r_res, n_res;
    logic                  r_ov, n_ov;
    t_out_beat             r_out, n_out;

    logic [TAG_BITS-1:0]   r_tag [ENTRY_COUNT];
    logic [TAG_BITS-1:0]   n_tag [ENTRY_COUNT];
    logic [REF_BITS-1:0]   r_ref [ENTRY_COUNT];
    logic [REF_BITS-1:0]   n_ref [ENTRY_COUNT];
    logic                  r_valid [ENTRY_COUNT];
    logic                  n_valid [ENTRY_COUNT];
    logic                  r_page [ENTRY_COUNT];
    logic                  n_page [ENTRY_COUNT];
    logic [LINK_W-1:0]     r_next [SLOTS];
    logic [LINK_W-1:0]     n_next [SLOTS];
    logic [LINK_W-1:0]     r_prev [SLOTS];
    logic [LINK_W-1:0]     n_prev [SLOTS];

    t_unit_req             s_req;
    t_unit_rsp             s_rsp;
    logic [IDX_W-1:0]      s_eidx;
    logic [IDX_W-1:0]      s_pidx;
    logic                  s_ptr_entry;
    logic                  s_can_load;
    logic [LINK_W-1:0]     s_n, s_p, s_n2;

    bbc_unit u_unit (
        .i_req (s_req),
        .o_rsp (s_rsp)
    );

    assign s_eidx      = r_ptr[IDX_W-1:0];
    assign s_pidx      = IDX_W'(r_item.entry_index);
    assign s_ptr_entry = (r_ptr < ACT_HEAD);
    assign s_can_load  = !r_ov || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    always_comb begin
        s_req.op     = U_MATCH;
        s_req.tag_a  = r_tag[s_eidx];
        s_req.tag_b  = r_item.block_tag;
        s_req.ref_in = r_ref[s_eidx];
        case (r_state)
            S_SRCH_A: begin
                s_req.op = U_INC;
            end
            S_PUT: begin
                s_req.op     = U_DEC;
                s_req.ref_in = r_ref[s_pidx];
            end
            default: begin
                s_req.op = U_MATCH;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_ptr      = r_ptr;
        n_steps    = r_steps;
        n_freed    = r_freed;
        n_mv_e     = r_mv_e;
        n_mv_head  = r_mv_head;
        n_ret_free = r_ret_free;
        n_res      = r_res;
        n_ov       = r_ov;
        n_out      = r_out;
        n_tag      = r_tag;
        n_ref      = r_ref;
        n_valid    = r_valid;
        n_page     = r_page;
        n_next     = r_next;
        n_prev     = r_prev;
        s_n        = r_next[r_mv_e];
        s_p        = r_prev[r_mv_e];
        s_n2       = r_next[r_mv_head];

        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item     = i_in_data;
                    n_steps    = '0;
                    n_freed    = '0;
                    n_ret_free = 1'b0;
                    n_res      = '0;
                    n_res.last = 1'b1;
                    case (i_in_data.mode)
                        MODE_GET: begin
                            n_ptr   = r_next[ACT_HEAD];
                            n_state = S_SRCH_A;
                        end
                        MODE_PUT: begin
                            n_state = S_PUT;
                        end
                        MODE_FREE: begin
                            n_ptr   = r_next[INA_HEAD];
                            n_state = S_FREE;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SRCH_A: begin
                if (r_ptr == ACT_HEAD || !s_ptr_entry || int'(r_steps) == ENTRY_COUNT) begin
                    n_ptr   = r_next[INA_HEAD];
                    n_steps = '0;
                    n_state = S_SRCH_I;
                end else if (r_valid[s_eidx] && s_rsp.match) begin
                    n_ref[s_eidx]      = s_rsp.ref_out;
                    n_res.status       = ST_HIT;
                    n_res.result_index = 4'(s_eidx);
                    n_state            = S_EMIT;
                end else begin
                    n_ptr   = r_next[r_ptr];
                    n_steps = r_steps + CNT_W'(1);
                end
            end
            S_SRCH_I: begin
                if (r_ptr == INA_HEAD || !s_ptr_entry || int'(r_steps) == ENTRY_COUNT) begin
                    if (r_next[INA_HEAD] >= ACT_HEAD) begin
                        n_res.status = ST_FULL;
                        n_state      = S_EMIT;
                    end else begin
                        n_mv_e             = r_next[INA_HEAD][IDX_W-1:0];
                        n_tag[n_mv_e]      = r_item.block_tag;
                        n_valid[n_mv_e]    = 1'b1;
                        n_ref[n_mv_e]      = REF_ONE;
                        n_page[n_mv_e]     = 1'b1;
                        n_res.status       = ST_MISS;
                        n_res.result_index = 4'(n_mv_e);
                        n_res.need_page    = !r_page[n_mv_e];
                        n_res.need_read    = 1'b1;
                        n_mv_head          = ACT_HEAD;
                        n_state            = S_UNLINK;
                    end
                end else if (r_valid[s_eidx] && s_rsp.match) begin
                    n_ref[s_eidx]      = REF_ONE;
                    n_mv_e             = s_eidx;
                    n_mv_head          = ACT_HEAD;
                    n_res.status       = ST_REVIVE;
                    n_res.result_index = 4'(s_eidx);
                    n_state            = S_UNLINK;
                end else begin
                    n_ptr   = r_next[r_ptr];
                    n_steps = r_steps + CNT_W'(1);
                end
            end
            S_PUT: begin
                n_res.result_index = r_item.entry_index;
                if (int'(r_item.entry_index) >= ENTRY_COUNT || r_ref[s_pidx] == '0) begin
                    n_res.status = ST_UNDERFLOW;
                    n_state      = S_EMIT;
                end else begin
                    n_ref[s_pidx] = s_rsp.ref_out;
                    n_res.status  = ST_PUT_OK;
                    if (s_rsp.ref_out == '0) begin
                        n_mv_e    = s_pidx;
                        n_mv_head = INA_HEAD;
                        n_state   = S_UNLINK;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_FREE: begin
                n_res = '0;
                if (r_ptr != INA_HEAD && s_ptr_entry
                        && int'(r_freed) < int'(r_item.free_limit)
                        && int'(r_steps) < ENTRY_COUNT) begin
                    n_ptr   = r_next[r_ptr];
                    n_steps = r_steps + CNT_W'(1);
                    if (r_page[s_eidx]) begin
                        n_page[s_eidx]     = 1'b0;
                        n_valid[s_eidx]    = 1'b0;
                        n_freed            = r_freed + CNT_W'(1);
                        n_res.result_index = 4'(s_eidx);
                        n_res.page_freed   = 1'b1;
                        n_ret_free         = 1'b1;
                        n_state            = S_EMIT;
                    end
                end else begin
                    n_res.freed_count = 5'(r_freed);
                    n_res.last        = 1'b1;
                    n_ret_free        = 1'b0;
                    n_state           = S_EMIT;
                end
            end
            S_UNLINK: begin
                n_next[s_p] = s_n;
                n_prev[s_n] = s_p;
                n_state     = S_LINK;
            end
            S_LINK: begin
                n_next[r_mv_e]    = s_n2;
                n_prev[s_n2]      = LINK_W'(r_mv_e);
                n_prev[r_mv_e]    = r_mv_head;
                n_next[r_mv_head] = LINK_W'(r_mv_e);
                n_state           = S_EMIT;
            end
            S_EMIT: begin
                if (s_can_load) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = r_ret_free ? S_FREE : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ov       <= 1'b0;
            r_ret_free <= 1'b0;
            for (int i = 0; i < ENTRY_COUNT; i++) begin
                r_tag[i]   <= '0;
                r_ref[i]   <= '0;
                r_valid[i] <= 1'b0;
                r_page[i]  <= 1'b0;
                r_next[i]  <= (i == 0) ? INA_HEAD : LINK_W'(i - 1);
                r_prev[i]  <= (i == ENTRY_COUNT - 1) ? INA_HEAD : LINK_W'(i + 1);
            end
            r_next[ACT_HEAD] <= ACT_HEAD;
            r_prev[ACT_HEAD] <= ACT_HEAD;
            r_next[INA_HEAD] <= LINK_W'(ENTRY_COUNT - 1);
            r_prev[INA_HEAD] <= '0;
        end else begin
            r_state    <= n_state;
            r_ov       <= n_ov;
            r_ret_free <= n_ret_free;
            r_tag      <= n_tag;
            r_ref      <= n_ref;
            r_valid    <= n_valid;
            r_page     <= n_page;
            r_next     <= n_next;
            r_prev     <= n_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_ptr     <= n_ptr;
        r_steps   <= n_steps;
        r_freed   <= n_freed;
        r_mv_e    <= n_mv_e;
        r_mv_head <= n_mv_head;
        r_res     <= n_res;
        r_out     <= n_out;
    end

endmodule

// ===== sv/bbc_unit.sv =====
// ----------------------------------------------------------------------------
// bbc_unit
// Shared tag compare and reference count unit.
// ----------------------------------------------------------------------------
module bbc_unit import bbc_pkg::*; (
    input  t_unit_req i_req,
    output t_unit_rsp o_rsp
);

    always_comb begin
        o_rsp.match   = (i_req.tag_a == i_req.tag_b);
        o_rsp.ref_out = i_req.ref_in;
        case (i_req.op)
            U_INC: begin
                if (i_req.ref_in != REF_MAX) begin
                    o_rsp.ref_out = i_req.ref_in + REF_ONE;
                end
            end
            U_DEC: begin
                o_rsp.ref_out = i_req.ref_in - REF_ONE;
            end
            U_MATCH: begin
                o_rsp.ref_out = i_req.ref_in;
            end
            default: begin
                o_rsp.ref_out = i_req.ref_in;
            end
        endcase
    end

endmodule

// ===== sv/bbc_checker.sv =====
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks for the buffer cache list manager.
// ----------------------------------------------------------------------------
module bbc_checker import bbc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear channels");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.mode != MODE_NONE |=> o_in_stall)
        else $error("second beat accepted while busy");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_HIT |-> o_out_data.last)
        else $error("get or put beat without last");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.page_freed |-> !o_out_data.last
            && o_out_data.freed_count == 5'd0)
        else $error("freed page beat malformed");

endmodule

bind block_buffer_cache_lists_core bbc_checker u_bbc_checker (.*);
